FILE: rtl/core/brf_pkg.sv
// ----------------------------------------------------------------------------
// brf_pkg
// Shared types, constants and the key table for the byte ring FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

package brf_pkg;

  localparam int DEPTH = 256;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int LEN_W = PTR_W + 1;
  localparam int BYTE_W = 8;
  localparam int CFG_W = LEN_W;

  localparam int KEY_LEN = 11;
  localparam int LAST_KEY_INDEX = 10;
  localparam int FULL_MATCH = 12;
  localparam int KCNT_W = 4;

  // dividend width of the count unit (wrap of the pointer difference)
  localparam int DIV_W = 32;
  localparam int STEP_W = $clog2(DIV_W);

  typedef enum logic [1:0] {
    KIND_PUSH  = 2'd0,
    KIND_POP   = 2'd1,
    KIND_FLUSH = 2'd2
  } kind_t;

  localparam logic CFG_USED_LENGTH = 1'b0;
  localparam logic CFG_BOOT_ID     = 1'b1;

  typedef struct packed {
    logic             valid;
    logic [PTR_W-1:0] wp;
    logic [PTR_W-1:0] rp;
    logic [LEN_W-1:0] len;
  } cnt_req_t;

  typedef struct packed {
    logic             done;
    logic [PTR_W-1:0] count;
  } cnt_resp_t;

  // key "PC 5A5AA5A5"
  function automatic logic [BYTE_W-1:0] key_char(input logic [KCNT_W-1:0] idx);
    logic [BYTE_W-1:0] c;
    case (idx)
      4'd0:    c = 8'h50;
      4'd1:    c = 8'h43;
      4'd2:    c = 8'h20;
      4'd3:    c = 8'h35;
      4'd4:    c = 8'h41;
      4'd5:    c = 8'h35;
      4'd6:    c = 8'h41;
      4'd7:    c = 8'h41;
      4'd8:    c = 8'h35;
      4'd9:    c = 8'h41;
      4'd10:   c = 8'h35;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/byte_ring_fifo_with_key_detect.sv
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_key_detect
// Byte ring FIFO with programmable ring length and a boot key detector.
// ----------------------------------------------------------------------------
// Sequence: accept in idle; a pop that returns a byte reads the RAM (S_RD),
//   then every item requests a count (S_REQ) and waits for it (S_WAIT). The
//   count unit runs a bit-serial remainder by the ring length when
//   wp + len - rp is 2*len or more or negative, else it takes a fast path.
// Throughput: one item at a time; busy is low again in the cycle out_valid
//   is shown. The receiver cannot stall.
// Reset (rst_n, synchronous): pointers, key counters and control cleared,
//   length 256, boot id 0. Ring RAM contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_ring_fifo_with_key_detect (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // item command
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    in_kind,
  input  wire logic [brf_pkg::BYTE_W-1:0]    in_data_in,
  // result
  output logic                               out_valid,
  output logic [brf_pkg::BYTE_W-1:0]         out_data_out,
  output logic                               out_ok,
  output logic [brf_pkg::PTR_W-1:0]          out_available,
  output logic                               out_boot_request,
  // configuration
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_idx,
  input  wire logic [brf_pkg::CFG_W-1:0]     cfg_wdata
);
  import brf_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_REQ,
    S_WAIT
  } state_t;

  state_t state_r;

  // config registers
  logic [LEN_W-1:0]  used_len_r;
  logic [BYTE_W-1:0] boot_id_r;
  logic [LEN_W-1:0]  len;

  // ring pointers
  logic [PTR_W-1:0]  wp_r;
  logic [PTR_W-1:0]  rp_r;
  logic [PTR_W-1:0]  wp_adv;
  logic [PTR_W-1:0]  rp_adv;

  // result registers
  logic              out_valid_r;
  logic [BYTE_W-1:0] data_out_r;
  logic              ok_r;
  logic [PTR_W-1:0]  avail_r;
  logic              boot_r;

  // RAM / detector / count unit hookup
  logic              ram_we;
  logic              ram_re;
  logic [BYTE_W-1:0] ram_rdata;
  logic              accept;
  logic              det_hit;
  cnt_req_t          cnt_req;
  cnt_resp_t         cnt_resp;

  // advance with wrap at the ring length; a pointer left beyond a
  // shortened length also wraps to zero
  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                               input logic [LEN_W-1:0] l);
    logic [LEN_W-1:0] n;
    n = LEN_W'(p) + 1'b1;
    return (n >= l) ? '0 : n[PTR_W-1:0];
  endfunction

  // effective length, clamped to 2..DEPTH
  always_comb begin
    if (used_len_r < LEN_W'(2)) begin
      len = LEN_W'(2);
    end else if (used_len_r > LEN_W'(DEPTH)) begin
      len = LEN_W'(DEPTH);
    end else begin
      len = used_len_r;
    end
  end

  assign wp_adv = advance(wp_r, len);
  assign rp_adv = advance(rp_r, len);
  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  // push writes the slot under wp when the ring is not full
  assign ram_we = accept && (in_kind == KIND_PUSH) && (wp_adv != rp_r);
  // pop reads the slot under rp when the ring is not empty
  assign ram_re = accept && (in_kind == KIND_POP) && (rp_r != wp_r);

  brf_ram #(
    .AW (PTR_W),
    .DW (BYTE_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (in_data_in),
    .re    (ram_re),
    .raddr (rp_r),
    .rdata (ram_rdata)
  );

  brf_key_det u_det (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (state_r == S_RD),
    .byte_in (ram_rdata),
    .boot_id (boot_id_r),
    .hit     (det_hit)
  );

  // count is taken from the pointers after the operation
  assign cnt_req.valid = (state_r == S_REQ);
  assign cnt_req.wp    = wp_r;
  assign cnt_req.rp    = rp_r;
  assign cnt_req.len   = len;

  brf_cnt u_cnt (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (cnt_req),
    .resp (cnt_resp)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_len_r <= LEN_W'(DEPTH);
      boot_id_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_USED_LENGTH: used_len_r <= cfg_wdata;
        CFG_BOOT_ID:     boot_id_r  <= cfg_wdata[BYTE_W-1:0];
        default:         used_len_r <= used_len_r;
      endcase
    end
  end

  // sequencer: accept, optional RAM read, count, then one-cycle result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      rp_r        <= '0;
      out_valid_r <= 1'b0;
      ok_r        <= 1'b0;
      boot_r      <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            data_out_r <= '0;
            boot_r     <= 1'b0;
            ok_r       <= 1'b0;
            state_r    <= S_REQ;
            case (kind_t'(in_kind))
              KIND_PUSH: begin
                if (wp_adv != rp_r) begin
                  wp_r <= wp_adv;
                  ok_r <= 1'b1;
                end
              end
              KIND_POP: begin
                if (rp_r != wp_r) begin
                  state_r <= S_RD;
                end
              end
              KIND_FLUSH: begin
                wp_r <= '0;
                rp_r <= '0;
                ok_r <= 1'b1;
              end
              default: ok_r <= 1'b0;
            endcase
          end
        end
        S_RD: begin
          // read data is here; detector steps on the same edge
          data_out_r <= ram_rdata;
          ok_r       <= 1'b1;
          boot_r     <= det_hit;
          rp_r       <= rp_adv;
          state_r    <= S_REQ;
        end
        S_REQ: begin
          state_r <= S_WAIT;
        end
        S_WAIT: begin
          if (cnt_resp.done) begin
            avail_r     <= cnt_resp.count;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_data_out     = data_out_r;
  assign out_ok           = ok_r;
  assign out_available    = avail_r;
  assign out_boot_request = boot_r;

endmodule

`default_nettype wire

FILE: rtl/core/brf_ram.sv
// ----------------------------------------------------------------------------
// brf_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module brf_ram #(
  parameter int AW = 8,
  parameter int DW = 8
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: rtl/core/brf_key_det.sv
// ----------------------------------------------------------------------------
// brf_key_det
// Key plus boot identity detector on the stream of popped bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module brf_key_det (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire logic [brf_pkg::BYTE_W-1:0] byte_in,
  input  wire logic [brf_pkg::BYTE_W-1:0] boot_id,
  output logic                       hit
);
  import brf_pkg::*;

  logic [KCNT_W-1:0] kpos_r, kpos_nxt;
  logic [KCNT_W-1:0] mcnt_r, mcnt_nxt;

  always_comb begin
    kpos_nxt = kpos_r;
    mcnt_nxt = mcnt_r;
    hit      = 1'b0;
    if (mcnt_r <= KCNT_W'(LAST_KEY_INDEX)) begin
      if (kpos_r < KCNT_W'(KEY_LEN) && key_char(kpos_r) == byte_in) begin
        kpos_nxt = kpos_r + 1'b1;
        mcnt_nxt = mcnt_r + 1'b1;
      end else begin
        kpos_nxt = '0;
        mcnt_nxt = '0;
      end
    end else if (byte_in == boot_id) begin
      mcnt_nxt = mcnt_r + 1'b1;
    end else begin
      kpos_nxt = '0;
      mcnt_nxt = '0;
    end
    if (mcnt_nxt >= KCNT_W'(FULL_MATCH)) begin
      hit      = 1'b1;
      kpos_nxt = '0;
      mcnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kpos_r <= '0;
      mcnt_r <= '0;
    end else if (en) begin
      kpos_r <= kpos_nxt;
      mcnt_r <= mcnt_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/brf_cnt.sv
// ----------------------------------------------------------------------------
// brf_cnt
// Byte count: (wp + len - rp) mod len, with 32-bit wrap of the difference.
// A fast path for in-range pointers, otherwise a bit-serial restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none

module brf_cnt (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire brf_pkg::cnt_req_t  req,
  output brf_pkg::cnt_resp_t      resp
);
  import brf_pkg::*;

  localparam int S_W = LEN_W + 2;

  logic [S_W-1:0]    diff;
  logic              neg;
  logic              fast;
  logic [S_W-1:0]    fast_sub;
  logic [PTR_W-1:0]  fast_res;

  logic              active_r;
  logic              done_r;
  logic [PTR_W-1:0]  count_r;
  logic [DIV_W-1:0]  dvd_r;
  logic [PTR_W-1:0]  rem_r;
  logic [LEN_W-1:0]  len_r;
  logic [STEP_W-1:0] step_r;

  logic [LEN_W-1:0]  trial;
  logic [PTR_W-1:0]  rem_nxt;

  assign diff = S_W'(req.wp) + S_W'(req.len) - S_W'(req.rp);
  assign neg  = diff[S_W-1];
  assign fast = !neg && (diff < {1'b0, req.len, 1'b0});
  assign fast_sub = diff - S_W'(req.len);
  assign fast_res = (diff >= S_W'(req.len)) ? fast_sub[PTR_W-1:0] : diff[PTR_W-1:0];

  // one quotient bit per cycle; remainder stays below len
  assign trial   = {rem_r, dvd_r[DIV_W-1]};
  assign rem_nxt = (trial >= len_r) ? PTR_W'(trial - len_r) : trial[PTR_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.valid) begin
        len_r <= req.len;
        rem_r <= '0;
        if (fast) begin
          count_r <= fast_res;
          done_r  <= 1'b1;
        end else begin
          active_r <= 1'b1;
          if (neg) begin
            dvd_r  <= {{(DIV_W-S_W){diff[S_W-1]}}, diff};
            step_r <= STEP_W'(DIV_W - 1);
          end else begin
            dvd_r  <= {diff, {(DIV_W-S_W){1'b0}}};
            step_r <= STEP_W'(S_W - 1);
          end
        end
      end else if (active_r) begin
        rem_r  <= rem_nxt;
        dvd_r  <= {dvd_r[DIV_W-2:0], 1'b0};
        step_r <= step_r - 1'b1;
        if (step_r == '0) begin
          active_r <= 1'b0;
          done_r   <= 1'b1;
          count_r  <= rem_nxt;
        end
      end
    end
  end

  assign resp.done  = done_r;
  assign resp.count = count_r;

endmodule

`default_nettype wire
